[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the hash map RTL.
// Each macro expects a clock named clk and an active-high reset named rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OAH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/oah_pkg.sv]
// ----------------------------------------------------------------------------
// oah_pkg
// Field widths, operation and slot codes, and the command and status bundles
// that join the hash map controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oah_pkg;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int HASH_W  = 32;
  localparam int IDX_W   = 4;
  localparam int FOUND_W = 5;
  localparam int STATE_W = 2;
  localparam int TOTAL_W = 5;

  localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  localparam logic [STATE_W-1:0] ST_EMPTY   = 2'd0;
  localparam logic [STATE_W-1:0] ST_FILLED  = 2'd1;
  localparam logic [STATE_W-1:0] ST_REMOVED = 2'd2;

  // The hash reduction has this many steps: reciprocal product, quotient,
  // remainder.
  localparam int MOD_STEPS = 3;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  // Result selection codes.
  localparam int RES_W = 3;
  localparam logic [RES_W-1:0] RES_NONE  = 3'd0;
  localparam logic [RES_W-1:0] RES_FAIL  = 3'd1;
  localparam logic [RES_W-1:0] RES_OK    = 3'd2;
  localparam logic [RES_W-1:0] RES_FOUND = 3'd3;
  localparam logic [RES_W-1:0] RES_READ  = 3'd4;

  typedef struct packed {
    logic             capture;
    logic             mod_step;
    logic             probe_start;
    logic             probe;
    logic             wr_add;
    logic             wr_erase;
    logic             sweep_init;
    logic             sweep;
    logic [RES_W-1:0] res_sel;
    logic             load_out;
  } oah_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            table_full;
    logic            mod_last;
    logic            sweep_last;
    logic            q_live;
    logic            exhausted;
    logic            q_filled;
    logic            q_empty;
    logic            key_eq;
    logic            idx_ok;
  } oah_sts_t;

endpackage

[hdl/oah_req_if.sv]
// ----------------------------------------------------------------------------
// oah_req_if
// Request channel of the hash map: valid/ready handshake and one operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface oah_req_if
  import oah_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  logic [HASH_W-1:0]  key_hash;
  logic [IDX_W-1:0]   slot_index;

  modport source (output valid, operation, key, value, key_hash, slot_index, input ready);
  modport sink   (input valid, operation, key, value, key_hash, slot_index, output ready);
endinterface

[hdl/oah_rsp_if.sv]
// ----------------------------------------------------------------------------
// oah_rsp_if
// Response channel of the hash map: valid/ready handshake and one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface oah_rsp_if
  import oah_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [FOUND_W-1:0] found_slot;
  logic [KEY_W-1:0]   out_key;
  logic [VALUE_W-1:0] out_value;
  logic [STATE_W-1:0] slot_state;
  logic [TOTAL_W-1:0] entry_total;
  logic               is_empty;

  modport source (output valid, ok, found_slot, out_key, out_value, slot_state,
                  entry_total, is_empty, input ready);
  modport sink   (input valid, ok, found_slot, out_key, out_value, slot_state,
                  entry_total, is_empty, output ready);
endinterface

[hdl/oah_datapath.sv]
// ----------------------------------------------------------------------------
// oah_datapath
// Slot tables, hash reduction, probe address walk, entry count and the
// result and output registers of the hash map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oah_datapath
  import oah_pkg::*;
#(
  parameter int TABLE_SLOTS = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  oah_cmd_t           cmd,
  output oah_sts_t           sts,
  input  logic [OP_W-1:0]    operation,
  input  logic [KEY_W-1:0]   key,
  input  logic [VALUE_W-1:0] value,
  input  logic [HASH_W-1:0]  key_hash,
  input  logic [IDX_W-1:0]   slot_index,
  output logic               ok,
  output logic [FOUND_W-1:0] found_slot,
  output logic [KEY_W-1:0]   out_key,
  output logic [VALUE_W-1:0] out_value,
  output logic [STATE_W-1:0] slot_state,
  output logic [TOTAL_W-1:0] entry_total,
  output logic               is_empty
);

  localparam int AW     = $clog2(TABLE_SLOTS);
  localparam int CW     = $clog2(TABLE_SLOTS + 1);
  localparam int PROD_W = 2 * HASH_W;
  localparam logic [AW:0]        SLOTS_W   = (AW + 1)'(TABLE_SLOTS);
  localparam logic [AW-1:0]      LAST_SLOT = AW'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0]      FULL_CNT  = CW'(TABLE_SLOTS);
  localparam logic [FOUND_W-1:0] NOT_FOUND = FOUND_W'(TABLE_SLOTS);

  // Rounded reciprocal of the slot count for a HASH_W-bit dividend.
  localparam logic [HASH_W-1:0] RECIP =
    HASH_W'((64'd1 << HASH_W) * 64'((1 << AW) - TABLE_SLOTS) / 64'(TABLE_SLOTS) + 64'd1);

  // Steps of the hash reduction.
  localparam logic [MOD_CNT_W-1:0] STEP_MUL  = MOD_CNT_W'(0);
  localparam logic [MOD_CNT_W-1:0] STEP_QUOT = MOD_CNT_W'(1);

  // Slot tables.
  logic [STATE_W-1:0]    status_mem [TABLE_SLOTS];
  logic [KEY_BITS-1:0]   key_mem    [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] value_mem  [TABLE_SLOTS];

  // Captured item.
  logic [OP_W-1:0]       op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [IDX_W-1:0]      idx_r;

  // Hash reduction.
  logic [HASH_W-1:0]    hash_r;
  logic [PROD_W-1:0]    recip_prod;
  logic [HASH_W-1:0]    prod_hi;
  logic [HASH_W-1:0]    quot;
  logic [HASH_W-1:0]    quot_next;
  logic [AW-1:0]        rem;
  logic [AW-1:0]        rem_next;
  logic [MOD_CNT_W-1:0] mod_cnt;

  // Probe walk and sweep.
  logic [AW-1:0] paddr;
  logic [AW:0]   issued;
  logic [AW-1:0] sweep_addr;
  logic [AW-1:0] slot_addr;
  logic [AW-1:0] rd_addr;

  // Registered read data.
  logic [STATE_W-1:0]    st_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [AW-1:0]         q_addr;
  logic                  q_live;

  logic [CW-1:0] entry_count;

  // Status table write port.
  logic               st_we;
  logic [AW-1:0]      st_wa;
  logic [STATE_W-1:0] st_wd;

  // Staged result.
  logic               r_ok;
  logic [FOUND_W-1:0] r_found;
  logic [KEY_W-1:0]   r_key;
  logic [VALUE_W-1:0] r_val;
  logic [STATE_W-1:0] r_state;

  assign slot_addr = AW'(idx_r);
  assign rd_addr   = cmd.probe ? paddr : slot_addr;

  // Hash modulo slot count by reciprocal multiplication, one step per cycle:
  // high word of hash times reciprocal, then the quotient, then the remainder.
  // Only the low AW bits of the remainder are needed, so the last product is small.
  assign recip_prod = PROD_W'(hash_r) * PROD_W'(RECIP);
  assign quot_next  = (prod_hi + ((hash_r - prod_hi) >> 1)) >> (AW - 1);
  assign rem_next   = hash_r[AW-1:0] - AW'(quot[AW-1:0] * SLOTS_W);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= operation;
      key_r  <= KEY_BITS'(key);
      val_r  <= VALUE_BITS'(value);
      idx_r  <= slot_index;
      hash_r <= key_hash;
    end else if (cmd.mod_step) begin
      unique case (mod_cnt)
        STEP_MUL: begin
          prod_hi <= recip_prod[PROD_W-1:HASH_W];
        end
        STEP_QUOT: begin
          quot <= quot_next;
        end
        default: begin
          rem <= rem_next;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (cmd.capture) begin
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt <= mod_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issued <= '0;
      paddr  <= '0;
      q_live <= 1'b0;
    end else begin
      q_live <= cmd.probe && (issued != SLOTS_W);
      if (cmd.probe_start) begin
        paddr  <= rem;
        issued <= '0;
      end else if (cmd.probe && (issued != SLOTS_W)) begin
        paddr  <= (paddr == LAST_SLOT) ? '0 : paddr + 1'b1;
        issued <= issued + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr  <= '0;
      entry_count <= '0;
    end else begin
      if (cmd.sweep_init) begin
        sweep_addr <= '0;
      end else if (cmd.sweep) begin
        sweep_addr <= (sweep_addr == LAST_SLOT) ? '0 : sweep_addr + 1'b1;
      end
      if (cmd.sweep_init) begin
        entry_count <= '0;
      end else if (cmd.wr_add) begin
        entry_count <= entry_count + 1'b1;
      end else if (cmd.wr_erase) begin
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  always_comb begin
    st_we = cmd.sweep || cmd.wr_add || cmd.wr_erase;
    priority if (cmd.sweep) begin
      st_wa = sweep_addr;
      st_wd = ST_EMPTY;
    end else if (cmd.wr_add) begin
      st_wa = q_addr;
      st_wd = ST_FILLED;
    end else begin
      st_wa = slot_addr;
      st_wd = ST_REMOVED;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      status_mem[st_wa] <= st_wd;
    end
    if (cmd.wr_add) begin
      key_mem[q_addr]   <= key_r;
      value_mem[q_addr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    st_q   <= status_mem[rd_addr];
    key_q  <= key_mem[rd_addr];
    val_q  <= value_mem[rd_addr];
    q_addr <= rd_addr;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res_sel)
      RES_FAIL: begin
        r_ok    <= 1'b0;
        r_found <= NOT_FOUND;
        r_key   <= '0;
        r_val   <= '0;
        r_state <= ST_EMPTY;
      end
      RES_OK: begin
        r_ok    <= 1'b1;
        r_found <= NOT_FOUND;
        r_key   <= '0;
        r_val   <= '0;
        r_state <= ST_EMPTY;
      end
      RES_FOUND: begin
        r_ok    <= 1'b1;
        r_found <= FOUND_W'(q_addr);
        r_key   <= KEY_W'(key_q);
        r_val   <= VALUE_W'(val_q);
        r_state <= ST_EMPTY;
      end
      RES_READ: begin
        r_ok    <= 1'b1;
        r_found <= NOT_FOUND;
        if (st_q == ST_EMPTY) begin
          r_key   <= '0;
          r_val   <= '0;
          r_state <= ST_EMPTY;
        end else begin
          r_key   <= KEY_W'(key_q);
          r_val   <= VALUE_W'(val_q);
          r_state <= st_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ok          <= r_ok;
      found_slot  <= r_found;
      out_key     <= r_key;
      out_value   <= r_val;
      slot_state  <= r_state;
      entry_total <= TOTAL_W'(entry_count);
      is_empty    <= (entry_count == '0);
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.table_full = (entry_count >= FULL_CNT);
    sts.mod_last   = (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
    sts.sweep_last = (sweep_addr == LAST_SLOT);
    sts.q_live     = q_live;
    sts.exhausted  = (issued == SLOTS_W);
    sts.q_filled   = (st_q == ST_FILLED);
    sts.q_empty    = (st_q == ST_EMPTY);
    sts.key_eq     = (key_q == key_r);
    sts.idx_ok     = ({{(32 - IDX_W){1'b0}}, idx_r} < 32'(TABLE_SLOTS));
  end

endmodule

[hdl/oah_controller.sv]
// ----------------------------------------------------------------------------
// oah_controller
// Sequencer of the hash map: accepts one operation, steps the datapath
// through hashing, probing, slot access or a table sweep, and hands the result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oah_controller
  import oah_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  oah_sts_t        sts,
  output oah_cmd_t        cmd
);

  localparam logic [2:0] S_INIT      = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_CLEAR     = 3'd2;
  localparam logic [2:0] S_MOD       = 3'd3;
  localparam logic [2:0] S_PSTART    = 3'd4;
  localparam logic [2:0] S_PROBE     = 3'd5;
  localparam logic [2:0] S_SLOT      = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_eval;
  logic       slot_eval_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    slot_eval_next = 1'b0;
    in_ready       = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (in_op)
            OP_ADD: begin
              if (sts.table_full) begin
                cmd.res_sel = RES_FAIL;
                state_next  = S_DONE;
              end else begin
                state_next = S_MOD;
              end
            end
            OP_FIND: begin
              state_next = S_MOD;
            end
            OP_ERASE, OP_READ: begin
              state_next = S_SLOT;
            end
            OP_CLEAR: begin
              cmd.sweep_init = 1'b1;
              cmd.res_sel    = RES_OK;
              state_next     = S_CLEAR;
            end
            default: begin
              cmd.res_sel = RES_FAIL;
              state_next  = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.probe_start = 1'b1;
        state_next      = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.q_live) begin
          if (sts.op == OP_ADD) begin
            if (!sts.q_filled) begin
              cmd.wr_add  = 1'b1;
              cmd.res_sel = RES_OK;
              state_next  = S_DONE;
            end else if (sts.key_eq) begin
              cmd.res_sel = RES_FAIL;
              state_next  = S_DONE;
            end
          end else begin
            if (sts.q_filled && sts.key_eq) begin
              cmd.res_sel = RES_FOUND;
              state_next  = S_DONE;
            end else if (sts.q_empty) begin
              cmd.res_sel = RES_FAIL;
              state_next  = S_DONE;
            end
          end
        end else if (sts.exhausted) begin
          cmd.res_sel = RES_FAIL;
          state_next  = S_DONE;
        end
      end
      S_SLOT: begin
        // The addressed slot is read into the read registers first, then this state acts on the registered data.
        if (!slot_eval) begin
          slot_eval_next = 1'b1;
        end else begin
          state_next = S_DONE;
          if (sts.op == OP_ERASE) begin
            if (sts.idx_ok && sts.q_filled) begin
              cmd.wr_erase = 1'b1;
              cmd.res_sel  = RES_OK;
            end else begin
              cmd.res_sel = RES_FAIL;
            end
          end else begin
            cmd.res_sel = sts.idx_ok ? RES_READ : RES_FAIL;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      slot_eval <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      slot_eval <= slot_eval_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/open_addressing_hash_map.sv]
// Add and find run the hash reduction, a probe start, then one slot-table read per probe.
// Erase and read slot read the addressed slot and then act on it, clear sweeps the table,
// and a refused add or an unknown code goes straight to the result.
// One operation is in flight: the next transfer is taken the cycle after the result is
// loaded into the output register.
// After reset the status table is swept with ready low.
// ----------------------------------------------------------------------------
// open_addressing_hash_map
// Key/value map over a fixed slot table with linear probing and removed-slot
// markers. A controller sequences a datapath that holds the tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module open_addressing_hash_map
  import oah_pkg::*;
#(
  parameter int TABLE_SLOTS = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input logic        clk,
  input logic        rst,
  oah_req_if.sink    req,
  oah_rsp_if.source  rsp
);

  // Command and status bundles between the sequencer and the datapath.
  oah_cmd_t cmd;
  oah_sts_t sts;

  // The controller owns the handshakes. A request transfer is taken only in
  // its idle state; the result sits in an output register so the controller
  // can return to idle while the consumer still stalls.
  oah_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_op     (req.operation),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the status, key and value tables (one read port with
  // registered data, one write port each), the hash remainder unit, the probe
  // walk and the entry count.
  oah_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .operation   (req.operation),
    .key         (req.key),
    .value       (req.value),
    .key_hash    (req.key_hash),
    .slot_index  (req.slot_index),
    .ok          (rsp.ok),
    .found_slot  (rsp.found_slot),
    .out_key     (rsp.out_key),
    .out_value   (rsp.out_value),
    .slot_state  (rsp.slot_state),
    .entry_total (rsp.entry_total),
    .is_empty    (rsp.is_empty)
  );

  // An add only writes while there is room for one more entry.
  `OAH_ASSERT_SAME(a_add_has_room, cmd.wr_add, !sts.table_full, "add wrote into a full table")
  // An erase only hits an in-range slot that was read back as filled.
  `OAH_ASSERT_SAME(a_erase_filled, cmd.wr_erase, sts.idx_ok && sts.q_filled, "bad erase")
  // No request transfer is taken while the status table is being swept.
  `OAH_ASSERT_SAME(a_no_accept_in_sweep, cmd.sweep, !req.ready, "request taken during sweep")
  // Loading the output register always presents a result.
  `OAH_ASSERT_NEXT(a_load_shows_result, cmd.load_out, rsp.valid, "loaded result not presented")

endmodule

[verif/tb_open_addressing_hash_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_map
// Self-checking bench for the linear-probing hash map. Requests go in over the
// request channel and each response is checked against a behavioral copy of
// the slot table kept in the bench.
// ----------------------------------------------------------------------------

module tb_open_addressing_hash_map;
  import oah_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam logic [FOUND_W-1:0] NOT_FOUND = FOUND_W'(SLOTS);
  localparam int KEY_POOL = 24;
  localparam int REPORT_LIMIT = 10;

  // One request as it is driven onto the channel.
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [HASH_W-1:0]  key_hash;
    logic [IDX_W-1:0]   slot_index;
  } map_request_t;

  // One response, packed so that a whole response compares in one go.
  typedef struct packed {
    logic               ok;
    logic [FOUND_W-1:0] found_slot;
    logic [KEY_W-1:0]   out_key;
    logic [VALUE_W-1:0] out_value;
    logic [STATE_W-1:0] slot_state;
    logic [TOTAL_W-1:0] entry_total;
    logic               is_empty;
  } map_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  oah_req_if req();
  oah_rsp_if rsp();

  open_addressing_hash_map #(
    .TABLE_SLOTS(SLOTS),
    .KEY_BITS   (KEY_W),
    .VALUE_BITS (VALUE_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  // Bench copy of the table. It is updated the moment a request transfer
  // happens, so it always reflects every request the block has taken so far.
  logic [STATE_W-1:0] map_status [SLOTS];
  logic [KEY_W-1:0]   map_keys   [SLOTS];
  logic [VALUE_W-1:0] map_values [SLOTS];
  int unsigned        map_count;

  // Responses still owed by the block, oldest first.
  map_result_t pending_results[$];
  int          failure_count = 0;

  // Sender pacing: bursts of transfers separated by idle gaps. When
  // steady_sender is set the gaps are skipped entirely.
  int burst_left = 0;
  bit steady_sender = 1'b0;

  // Receiver pacing. A nonzero holdoff_left forces ready low and is counted
  // down to zero; otherwise the stall mode picks the pattern.
  int holdoff_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  int stall_tick = 0;

  // Key pool for the random traffic. Keys are reused so that finds hit and
  // duplicate adds happen; hashes are clustered so that probe chains form.
  logic [KEY_W-1:0]  key_pool  [KEY_POOL];
  logic [HASH_W-1:0] hash_pool [KEY_POOL];

  // Applies one request to the bench table and returns the response that
  // the block must produce for it.
  function automatic map_result_t hash_map_apply(map_request_t rq);
    map_result_t res;
    int unsigned start;
    int unsigned probe;
    res.ok          = 1'b0;
    res.found_slot  = NOT_FOUND;
    res.out_key     = '0;
    res.out_value   = '0;
    res.slot_state  = ST_EMPTY;
    start = rq.key_hash % SLOTS;
    case (rq.operation)
      OP_ADD: begin
        // A full table refuses the add before any probing.
        if (map_count < SLOTS) begin
          for (int a = 0; a < SLOTS; a++) begin
            probe = (start + a) % SLOTS;
            if (map_status[probe] != ST_FILLED) begin
              map_status[probe] = ST_FILLED;
              map_keys[probe]   = rq.key;
              map_values[probe] = rq.value;
              map_count++;
              res.ok = 1'b1;
              break;
            end
            // An equal key seen before the free slot makes the add fail.
            if (map_keys[probe] == rq.key) break;
          end
        end
      end
      OP_FIND: begin
        // Removed slots are stepped over; an empty slot ends the search.
        for (int a = 0; a < SLOTS; a++) begin
          probe = (start + a) % SLOTS;
          if (map_status[probe] == ST_FILLED) begin
            if (map_keys[probe] == rq.key) begin
              res.ok         = 1'b1;
              res.found_slot = FOUND_W'(probe);
              res.out_key    = map_keys[probe];
              res.out_value  = map_values[probe];
              break;
            end
          end else if (map_status[probe] != ST_REMOVED) begin
            break;
          end
        end
      end
      OP_ERASE: begin
        if (map_status[rq.slot_index] == ST_FILLED) begin
          map_status[rq.slot_index] = ST_REMOVED;
          map_count--;
          res.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int a = 0; a < SLOTS; a++) map_status[a] = ST_EMPTY;
        map_count = 0;
        res.ok = 1'b1;
      end
      OP_READ: begin
        // Every 4-bit index is in range. A removed slot still shows the key
        // and value it held last; an empty one shows zeros.
        res.ok = 1'b1;
        if (map_status[rq.slot_index] != ST_EMPTY) begin
          res.out_key    = map_keys[rq.slot_index];
          res.out_value  = map_values[rq.slot_index];
          res.slot_state = map_status[rq.slot_index];
        end
      end
      default: begin
        // Unknown operation codes are refused and change nothing.
      end
    endcase
    res.entry_total = TOTAL_W'(map_count);
    res.is_empty    = (map_count == 0);
    return res;
  endfunction

  // Sends one request. The task returns right after the transfer edge with
  // valid still high; the next call either replaces the payload or drops
  // valid at the following falling edge, so no item is offered twice.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [VALUE_W-1:0] v, input logic [HASH_W-1:0] h,
                              input logic [IDX_W-1:0] idx);
    map_request_t rq;
    int gap;
    rq.operation  = op;
    rq.key        = k;
    rq.value      = v;
    rq.key_hash   = h;
    rq.slot_index = idx;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req.valid      <= 1'b1;
    req.operation  <= op;
    req.key        <= k;
    req.value      <= v;
    req.key_hash   <= h;
    req.slot_index <= idx;
    forever begin
      @(posedge clk);
      if (req.ready) break;
    end
    pending_results.push_back(hash_map_apply(rq));
  endtask

  // Stops offering requests and waits until every owed response has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Checks each response transfer against the oldest owed response.
  always @(posedge clk) begin : check_results
    map_result_t want;
    map_result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.ok          = rsp.ok;
      got.found_slot  = rsp.found_slot;
      got.out_key     = rsp.out_key;
      got.out_value   = rsp.out_value;
      got.slot_state  = rsp.slot_state;
      got.entry_total = rsp.entry_total;
      got.is_empty    = rsp.is_empty;
      if (pending_results.size() == 0) begin
        if (failure_count < REPORT_LIMIT) begin
          $display("ERROR at %0t: response with none owed: ok=%0d slot=%0d key=%h value=%h",
                   $realtime, got.ok, got.found_slot, got.out_key, got.out_value);
        end
        failure_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (failure_count < REPORT_LIMIT) begin
            $display("ERROR at %0t: response mismatch", $realtime);
            $display("  expected ok=%0d slot=%0d key=%h value=%h state=%0d total=%0d empty=%0d",
                     want.ok, want.found_slot, want.out_key, want.out_value,
                     want.slot_state, want.entry_total, want.is_empty);
            $display("  actual   ok=%0d slot=%0d key=%h value=%h state=%0d total=%0d empty=%0d",
                     got.ok, got.found_slot, got.out_key, got.out_value,
                     got.slot_state, got.entry_total, got.is_empty);
          end
          failure_count++;
        end
      end
    end
  end

  // Response ready. Outside a forced hold-off the mode is picked at random from
  // always ready, two random duty cycles and a fixed one-in-five stall, so
  // stalls land on every phase of the block's work.
  always @(negedge clk) begin
    stall_tick++;
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_phase = $urandom_range(16, 96);
      end else begin
        stall_phase--;
      end
      case (stall_mode)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= ($urandom_range(0, 3) != 0);
        2:       rsp.ready <= (stall_tick % 5 != 0);
        default: rsp.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Basic adds and finds at the extremes of key, value and hash. The last
  // add starts at the top slot and has to wrap around to find room.
  task automatic test_add_find_basics();
    send_request(OP_ADD,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd0);
    send_request(OP_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(OP_FIND, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
    send_request(OP_FIND, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15);
    // Same key again from the same home slot must be refused.
    send_request(OP_ADD,  32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 4'd0);
    // Miss that stops at the first empty slot.
    send_request(OP_FIND, 32'h0000_1234, 32'h0, 32'h0000_0005, 4'd0);
    send_request(OP_READ, 32'h0, 32'h0, 32'h0, 4'd15);
    send_request(OP_READ, 32'h0, 32'h0, 32'h0, 4'd7);
    send_request(OP_ADD,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_000F, 4'd0);
  endtask

  // Removed-slot markers: finds step over them, a second erase is refused,
  // a removed slot still reads back its old contents, and an add stops at
  // the first removed slot even when the same key sits further along.
  task automatic test_removed_slots();
    send_request(OP_ADD,   32'h0000_0011, 32'h1111_1111, 32'h0000_0003, 4'd0);
    send_request(OP_ADD,   32'h0000_0022, 32'h2222_2222, 32'h0000_0013, 4'd0);
    send_request(OP_ADD,   32'h0000_0033, 32'h3333_3333, 32'h0000_0023, 4'd0);
    send_request(OP_ERASE, 32'h0, 32'h0, 32'h0, 4'd4);
    send_request(OP_FIND,  32'h0000_0033, 32'h0, 32'h0000_0003, 4'd0);
    send_request(OP_READ,  32'h0, 32'h0, 32'h0, 4'd4);
    send_request(OP_ERASE, 32'h0, 32'h0, 32'h0, 4'd4);
    send_request(OP_ADD,   32'h0000_0033, 32'h4444_4444, 32'h0000_0003, 4'd0);
    send_request(OP_FIND,  32'h0000_0033, 32'h0, 32'h0000_0003, 4'd0);
    send_request(OP_FIND,  32'h0000_0022, 32'h0, 32'h0000_0003, 4'd0);
    send_request(OP_ERASE, 32'h0, 32'h0, 32'h0, 4'd15);
    send_request(OP_ERASE, 32'h0, 32'h0, 32'h0, 4'd0);
  endtask

  // Codes above read slot are refused with nothing changed. A clear follows.
  task automatic test_unknown_codes();
    send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_request(3'd6, 32'h0000_0011, 32'h0, 32'h0000_0003, 4'd3);
    send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1);
    send_request(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the block backs up and stalls its request channel. Meanwhile the
  // table is filled from one home slot, an add into the full table is
  // refused, and the last key is found at the end of a full-length chain.
  task automatic test_backpressure_fill();
    logic [KEY_W-1:0]  k;
    logic [HASH_W-1:0] h;
    @(posedge clk);
    holdoff_left = 300;
    send_request(OP_CLEAR, $urandom, $urandom, $urandom, 4'($urandom));
    for (int n = 0; n < SLOTS; n++) begin
      k = $urandom;
      h = {28'($urandom), 4'd7};
      send_request(OP_ADD, k, $urandom, h, 4'($urandom));
    end
    send_request(OP_ADD, ~k, $urandom, h, 4'($urandom));
    send_request(OP_FIND, k, $urandom, h, 4'($urandom));
    send_request(OP_READ, $urandom, $urandom, $urandom, 4'd6);
    wait_for_results();
  endtask

  // Mostly well-formed traffic over a reused key pool, with some random
  // keys, clears and unknown codes mixed in. Every few hundred requests the
  // sender switches between bursty and steady pacing, and now and then it
  // pauses until the block has answered everything.
  task automatic test_random_traffic(input int count);
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;
    logic [HASH_W-1:0]  h;
    logic [IDX_W-1:0]   idx;
    int pick;
    int entry;
    int unsigned base;
    for (int n = 0; n < KEY_POOL; n++) begin
      key_pool[n]  = $urandom;
      hash_pool[n] = $urandom;
      // Half the pool crowds the top of the table so chains wrap.
      if (n % 2 == 0) hash_pool[n][3:0] = 4'($urandom_range(12, 15));
    end
    for (int n = 0; n < count; n++) begin
      if (n % 400 == 399) steady_sender = ~steady_sender;
      if (n % 250 == 249) wait_for_results();
      k     = $urandom;
      v     = $urandom;
      h     = $urandom;
      idx   = 4'($urandom);
      pick  = $urandom_range(0, 199);
      entry = $urandom_range(0, KEY_POOL - 1);
      if (pick < 72) begin
        op = OP_ADD;
        if ($urandom_range(0, 9) != 0) begin
          k = key_pool[entry];
          h = hash_pool[entry];
        end
      end else if (pick < 130) begin
        op = OP_FIND;
        if ($urandom_range(0, 9) < 8) begin
          k = key_pool[entry];
          h = hash_pool[entry];
        end
      end else if (pick < 158) begin
        op = OP_ERASE;
        // Usually aim at a filled slot so that erases mostly succeed.
        if (map_count > 0 && $urandom_range(0, 4) != 0) begin
          base = $urandom_range(0, SLOTS - 1);
          for (int a = 0; a < SLOTS; a++) begin
            if (map_status[(base + a) % SLOTS] == ST_FILLED) begin
              idx = IDX_W'((base + a) % SLOTS);
              break;
            end
          end
        end
      end else if (pick < 187) begin
        op = OP_READ;
      end else if (pick < 190) begin
        op = OP_CLEAR;
      end else begin
        op = OP_W'($urandom_range(5, 7));
      end
      send_request(op, k, v, h, idx);
    end
  endtask

  initial begin
    req.valid      = 1'b0;
    req.operation  = OP_ADD;
    req.key        = '0;
    req.value      = '0;
    req.key_hash   = '0;
    req.slot_index = '0;
    rsp.ready      = 1'b0;
    for (int a = 0; a < SLOTS; a++) map_status[a] = ST_EMPTY;
    map_count = 0;

    // Synchronous reset, released at a falling edge. The block then sweeps
    // its status table with ready low, which the first transfer simply waits out.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_add_find_basics();
    test_removed_slots();
    test_unknown_codes();
    test_backpressure_fill();
    test_random_traffic(2000);

    // Drain with a bound, then give the block time to show any stray
    // response beyond the longest operation latency.
    @(negedge clk);
    req.valid <= 1'b0;
    for (int w = 0; w < 20000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("ERROR: %0d responses never arrived", pending_results.size());
      failure_count++;
    end

    if (failure_count == 0) begin
      $display("tb_open_addressing_hash_map: PASS");
    end else begin
      $display("tb_open_addressing_hash_map: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run of this stimulus.
  initial begin
    #2000000;
    $display("ERROR: run did not complete in time");
    $display("tb_open_addressing_hash_map: FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/oah_pkg.sv
hdl/oah_req_if.sv
hdl/oah_rsp_if.sv
hdl/oah_datapath.sv
hdl/oah_controller.sv
hdl/open_addressing_hash_map.sv
verif/tb_open_addressing_hash_map.sv
